@@ rtl/ofwm_pkg.sv @@
// Shared constants, widths and types for the omni four-wheel mixer.
package ofwm_pkg;

   localparam int N_WHEELS = 4;
   localparam int CMD_W = 16;
   localparam int BIAS_W = 16;
   localparam int DUTY_W = 8;

   localparam int GAIN_XY = 717;
   localparam int GAIN_ROT_LOW = 307;
   localparam int GAIN_ROT_FULL = 1024;
   localparam int GAIN_W = 11;
   localparam int ROT_LIMIT = 10;
   localparam int DUTY_MAX = 255;
   localparam int PRODUCT_SHIFT = 22;

   localparam int SUM_W = CMD_W + 2;
   localparam int ROT_W = CMD_W + GAIN_W;
   localparam int MIX_W = ROT_W + 1;
   localparam int PROD_W = MIX_W + BIAS_W;
   localparam int MAG_W = PROD_W - PRODUCT_SHIFT;
   localparam int NUM_W = MAG_W + DUTY_W;
   localparam int QUO_W = DUTY_W;

   // wheel sign pattern: (+,+) (-,+) (-,-) (+,-)
   localparam logic [N_WHEELS-1:0] X_NEG = 4'b0110;
   localparam logic [N_WHEELS-1:0] Y_NEG = 4'b1100;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = $clog2(N_WHEELS);
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;
   localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd4096;

   // pipeline stage positions
   localparam int ST_SUM = 0;
   localparam int ST_MIX = 1;
   localparam int ST_PROD = 2;
   localparam int ST_MAG = 3;
   localparam int ST_PAIR = 4;
   localparam int ST_PEAK = 5;
   localparam int ST_DIV0 = 6;
   localparam int ST_OUT = ST_DIV0 + QUO_W;
   localparam int N_STAGES = ST_OUT + 1;

   typedef logic [N_WHEELS-1:0][BIAS_W-1:0] bias_set_type;

   typedef struct packed {
      logic [N_STAGES-1:0] load;
   } stage_ctrl_type;

   typedef struct packed {
      logic                           brake;
      logic [N_WHEELS-1:0]            neg;
      logic [N_WHEELS-1:0][MAG_W-1:0] mag;
   } mag_item_type;

   typedef struct packed {
      logic                            brake;
      logic [N_WHEELS-1:0]             neg;
      logic [N_WHEELS-1:0][DUTY_W-1:0] duty;
   } duty_item_type;

endpackage

@@ rtl/ofwm_channels.sv @@
// Command and duty channel interfaces of the omni four-wheel mixer.
interface ofwm_req_if;
   import ofwm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] move_x;
   logic signed [CMD_W-1:0] move_y;
   logic signed [CMD_W-1:0] turn_rate;
   logic                    brake;

   modport source (output valid, output move_x, output move_y, output turn_rate,
                   output brake, input ready);
   modport sink (input valid, input move_x, input move_y, input turn_rate,
                 input brake, output ready);
endinterface

interface ofwm_rsp_if;
   import ofwm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] w0_fwd_duty;
   logic [DUTY_W-1:0] w0_rev_duty;
   logic [DUTY_W-1:0] w1_fwd_duty;
   logic [DUTY_W-1:0] w1_rev_duty;
   logic [DUTY_W-1:0] w2_fwd_duty;
   logic [DUTY_W-1:0] w2_rev_duty;
   logic [DUTY_W-1:0] w3_fwd_duty;
   logic [DUTY_W-1:0] w3_rev_duty;

   modport source (output valid, output w0_fwd_duty, output w0_rev_duty,
                   output w1_fwd_duty, output w1_rev_duty, output w2_fwd_duty,
                   output w2_rev_duty, output w3_fwd_duty, output w3_rev_duty,
                   input ready);
   modport sink (input valid, input w0_fwd_duty, input w0_rev_duty,
                 input w1_fwd_duty, input w1_rev_duty, input w2_fwd_duty,
                 input w2_rev_duty, input w3_fwd_duty, input w3_rev_duty,
                 output ready);
endinterface

@@ rtl/ofwm_csr.sv @@
// APB register file holding the four wheel bias factors.
module ofwm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ofwm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ofwm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ofwm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output ofwm_pkg::bias_set_type             bias
);
   import ofwm_pkg::*;

   logic [BIAS_W-1:0]    bias_ff [N_WHEELS];
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(bias_ff[reg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < N_WHEELS; w++) begin
            bias_ff[w] <= BIAS_RESET;
         end
      end else if (wr_en) begin
         bias_ff[reg_idx] <= csr_pwdata[BIAS_W-1:0];
      end
   end

   always_comb begin
      for (int w = 0; w < N_WHEELS; w++) begin
         bias[w] = bias_ff[w];
      end
   end

endmodule

@@ rtl/ofwm_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the mixer pipeline.
module ofwm_pipe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output ofwm_pkg::stage_ctrl_type ctrl
);
   import ofwm_pkg::*;

   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] valid_in;
   logic [N_STAGES-1:0] upstream;
   logic [N_STAGES-1:0] load;

   // a stage loads when any stage at or after it is empty, or the output drains
   always_comb begin
      upstream = {valid_ff[N_STAGES-2:0], in_valid};
      for (int k = 0; k < N_STAGES; k++) begin
         load[k] = out_ready || (|(~valid_ff >> k));
         valid_in[k] = load[k] ? upstream[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = load[0];
   assign out_valid = valid_ff[N_STAGES-1];
   assign ctrl.load = load;

   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff))
      else $error("ready low with an empty stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   a_reset_empties: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

@@ rtl/ofwm_mix.sv @@
// Front stages: wheel mix, bias multiply and throttle magnitude.
module ofwm_mix (
   input  logic                          clock,
   input  ofwm_pkg::stage_ctrl_type      ctrl,
   input  logic signed [ofwm_pkg::CMD_W-1:0] move_x,
   input  logic signed [ofwm_pkg::CMD_W-1:0] move_y,
   input  logic signed [ofwm_pkg::CMD_W-1:0] turn_rate,
   input  logic                          brake,
   input  ofwm_pkg::bias_set_type        bias,
   output ofwm_pkg::mag_item_type        item
);
   import ofwm_pkg::*;

   logic signed [SUM_W-1:0]  x_ext;
   logic signed [SUM_W-1:0]  y_ext;
   logic signed [SUM_W-1:0]  sum_in [N_WHEELS];
   logic signed [SUM_W-1:0]  sum_ff [N_WHEELS];
   logic signed [ROT_W-1:0]  rot_in;
   logic signed [ROT_W-1:0]  rot_ff;
   logic signed [MIX_W-1:0]  mix_in [N_WHEELS];
   logic signed [MIX_W-1:0]  mix_ff [N_WHEELS];
   logic signed [PROD_W-1:0] prod_in [N_WHEELS];
   logic signed [PROD_W-1:0] prod_ff [N_WHEELS];
   logic [PROD_W-1:0]        abs_v [N_WHEELS];
   logic [MAG_W-1:0]         mag_in [N_WHEELS];
   logic [MAG_W-1:0]         mag_ff [N_WHEELS];
   logic [N_WHEELS-1:0]      neg_in;
   logic [N_WHEELS-1:0]      neg_ff;
   logic [ST_MAG:ST_SUM]     brake_ff;

   always_comb begin
      x_ext = SUM_W'(move_x);
      y_ext = SUM_W'(move_y);
      for (int w = 0; w < N_WHEELS; w++) begin
         sum_in[w] = (X_NEG[w] ? -x_ext : x_ext) + (Y_NEG[w] ? -y_ext : y_ext);
      end
      if (turn_rate > -ROT_LIMIT && turn_rate < ROT_LIMIT) begin
         rot_in = ROT_W'(turn_rate) * ROT_W'(GAIN_ROT_FULL);
      end else begin
         rot_in = ROT_W'(turn_rate) * ROT_W'(GAIN_ROT_LOW);
      end
      for (int w = 0; w < N_WHEELS; w++) begin
         mix_in[w] = MIX_W'(sum_ff[w]) * MIX_W'(GAIN_XY) + MIX_W'(rot_ff);
         prod_in[w] = PROD_W'(mix_ff[w]) * PROD_W'($signed(bias[w]));
         abs_v[w] = prod_ff[w][PROD_W-1] ? -prod_ff[w] : prod_ff[w];
         mag_in[w] = abs_v[w][PROD_W-1:PRODUCT_SHIFT];
         neg_in[w] = prod_ff[w][PROD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_SUM]) begin
         sum_ff <= sum_in;
         rot_ff <= rot_in;
         brake_ff[ST_SUM] <= brake;
      end
      if (ctrl.load[ST_MIX]) begin
         mix_ff <= mix_in;
         brake_ff[ST_MIX] <= brake_ff[ST_SUM];
      end
      if (ctrl.load[ST_PROD]) begin
         prod_ff <= prod_in;
         brake_ff[ST_PROD] <= brake_ff[ST_MIX];
      end
      if (ctrl.load[ST_MAG]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         brake_ff[ST_MAG] <= brake_ff[ST_PROD];
      end
   end

   always_comb begin
      item.brake = brake_ff[ST_MAG];
      item.neg = neg_ff;
      for (int w = 0; w < N_WHEELS; w++) begin
         item.mag[w] = mag_ff[w];
      end
   end

endmodule

@@ rtl/ofwm_scale.sv @@
// Back stages: peak magnitude search and pipelined rescale divider.
module ofwm_scale (
   input  logic                     clock,
   input  ofwm_pkg::stage_ctrl_type ctrl,
   input  ofwm_pkg::mag_item_type   item_in,
   output ofwm_pkg::duty_item_type  item_out
);
   import ofwm_pkg::*;

   typedef struct packed {
      logic                            brake;
      logic [N_WHEELS-1:0]             neg;
      logic [N_WHEELS-1:0][DUTY_W-1:0] lo;
      logic [N_WHEELS-1:0][NUM_W-1:0]  num;
      logic [MAG_W-1:0]                max_lo;
      logic [MAG_W-1:0]                max_hi;
   } pair_type;

   typedef struct packed {
      logic                            brake;
      logic [N_WHEELS-1:0]             neg;
      logic [N_WHEELS-1:0][DUTY_W-1:0] lo;
      logic [N_WHEELS-1:0][NUM_W-1:0]  num;
      logic [MAG_W-1:0]                max_mag;
      logic                            over;
   } peak_type;

   typedef struct packed {
      logic                            brake;
      logic [N_WHEELS-1:0]             neg;
      logic [N_WHEELS-1:0][DUTY_W-1:0] lo;
      logic                            over;
      logic [MAG_W-1:0]                divisor;
      logic [N_WHEELS-1:0][NUM_W-1:0]  rem;
      logic [N_WHEELS-1:0][QUO_W-1:0]  quo;
   } step_type;

   pair_type pair_in;
   pair_type pair_ff;
   peak_type peak_in;
   peak_type peak_ff;
   step_type step_src [QUO_W];
   step_type step_in [QUO_W];
   step_type step_ff [QUO_W];

   // pairwise max and numerator |t| * 255
   always_comb begin
      pair_in.brake = item_in.brake;
      pair_in.neg = item_in.neg;
      for (int w = 0; w < N_WHEELS; w++) begin
         pair_in.lo[w] = item_in.mag[w][DUTY_W-1:0];
         pair_in.num[w] = (NUM_W'(item_in.mag[w]) << DUTY_W) - NUM_W'(item_in.mag[w]);
      end
      pair_in.max_lo = (item_in.mag[1] > item_in.mag[0]) ? item_in.mag[1] : item_in.mag[0];
      pair_in.max_hi = (item_in.mag[3] > item_in.mag[2]) ? item_in.mag[3] : item_in.mag[2];
   end

   always_comb begin
      peak_in.brake = pair_ff.brake;
      peak_in.neg = pair_ff.neg;
      peak_in.lo = pair_ff.lo;
      peak_in.num = pair_ff.num;
      peak_in.max_mag = (pair_ff.max_hi > pair_ff.max_lo) ? pair_ff.max_hi : pair_ff.max_lo;
      peak_in.over = peak_in.max_mag > MAG_W'(DUTY_MAX);
   end

   // restoring division, one quotient bit per stage, msb first
   always_comb begin
      logic [NUM_W-1:0] trial;
      step_src[0].brake = peak_ff.brake;
      step_src[0].neg = peak_ff.neg;
      step_src[0].lo = peak_ff.lo;
      step_src[0].over = peak_ff.over;
      step_src[0].divisor = peak_ff.max_mag;
      step_src[0].rem = peak_ff.num;
      step_src[0].quo = '0;
      for (int j = 1; j < QUO_W; j++) begin
         step_src[j] = step_ff[j-1];
      end
      for (int j = 0; j < QUO_W; j++) begin
         step_in[j] = step_src[j];
         for (int w = 0; w < N_WHEELS; w++) begin
            trial = NUM_W'(step_src[j].divisor) << (QUO_W - 1 - j);
            if (step_src[j].rem[w] >= trial) begin
               step_in[j].rem[w] = step_src[j].rem[w] - trial;
               step_in[j].quo[w] = {step_src[j].quo[w][QUO_W-2:0], 1'b1};
            end else begin
               step_in[j].quo[w] = {step_src[j].quo[w][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PAIR]) begin
         pair_ff <= pair_in;
      end
      if (ctrl.load[ST_PEAK]) begin
         peak_ff <= peak_in;
      end
      for (int j = 0; j < QUO_W; j++) begin
         if (ctrl.load[ST_DIV0 + j]) begin
            step_ff[j] <= step_in[j];
         end
      end
   end

   always_comb begin
      item_out.brake = step_ff[QUO_W-1].brake;
      item_out.neg = step_ff[QUO_W-1].neg;
      for (int w = 0; w < N_WHEELS; w++) begin
         item_out.duty[w] = step_ff[QUO_W-1].over ? step_ff[QUO_W-1].quo[w]
                                                  : step_ff[QUO_W-1].lo[w];
      end
   end

endmodule

@@ rtl/omni_four_wheel_mixer.sv @@
// Top level of the omni four-wheel mixer: command in, eight bridge duties out.
//
//   channel   direction  handshake      contents
//   req_chan  in         valid/ready    move_x, move_y, turn_rate, brake
//   rsp_chan  out        valid/ready    w0..w3 fwd/rev duty, 8 bits each
//   csr_*     in         APB            wheel0..3 bias at 0x0, 0x4, 0x8, 0xC
//
// One word accepted per cycle while ready is high; 15 register stages, from the sum
// stage through the divider steps to the result register, from which the word leaves.
// Depth set mostly by the 8-stage restoring divider used for rescaling.
// Reset is synchronous: all stages empty, every bias back to 4096 (1.0).
// On a stall empty stages still fill; ready drops only when all 15 stages hold words.
module omni_four_wheel_mixer (
   input  logic                            clock,
   input  logic                            reset,
   ofwm_req_if.sink                        req_chan,
   ofwm_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ofwm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ofwm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ofwm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import ofwm_pkg::*;

   bias_set_type                    bias;
   stage_ctrl_type                  ctrl;
   mag_item_type                    mag_item;
   duty_item_type                   duty_item;
   logic                            in_ready;
   logic                            out_valid;
   logic [N_WHEELS-1:0][DUTY_W-1:0] fwd_in;
   logic [N_WHEELS-1:0][DUTY_W-1:0] rev_in;
   logic [N_WHEELS-1:0][DUTY_W-1:0] fwd_ff;
   logic [N_WHEELS-1:0][DUTY_W-1:0] rev_ff;

   ofwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bias        (bias)
   );

   ofwm_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   ofwm_mix u_mix (
      .clock     (clock),
      .ctrl      (ctrl),
      .move_x    (req_chan.move_x),
      .move_y    (req_chan.move_y),
      .turn_rate (req_chan.turn_rate),
      .brake     (req_chan.brake),
      .bias      (bias),
      .item      (mag_item)
   );

   ofwm_scale u_scale (
      .clock    (clock),
      .ctrl     (ctrl),
      .item_in  (mag_item),
      .item_out (duty_item)
   );

   always_comb begin
      for (int w = 0; w < N_WHEELS; w++) begin
         if (duty_item.brake) begin
            fwd_in[w] = DUTY_W'(DUTY_MAX);
            rev_in[w] = DUTY_W'(DUTY_MAX);
         end else if (duty_item.neg[w]) begin
            fwd_in[w] = '0;
            rev_in[w] = duty_item.duty[w];
         end else begin
            fwd_in[w] = duty_item.duty[w];
            rev_in[w] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign req_chan.ready = in_ready;
   assign rsp_chan.valid = out_valid;
   assign rsp_chan.w0_fwd_duty = fwd_ff[0];
   assign rsp_chan.w0_rev_duty = rev_ff[0];
   assign rsp_chan.w1_fwd_duty = fwd_ff[1];
   assign rsp_chan.w1_rev_duty = rev_ff[1];
   assign rsp_chan.w2_fwd_duty = fwd_ff[2];
   assign rsp_chan.w2_rev_duty = rev_ff[2];
   assign rsp_chan.w3_fwd_duty = fwd_ff[3];
   assign rsp_chan.w3_rev_duty = rev_ff[3];

endmodule

@@ sim/tb_omni_four_wheel_mixer.sv @@
// Self-checking testbench for the omni four-wheel mixer: command stream vs. duty predictor.
`timescale 1ns / 100ps

module tb_omni_four_wheel_mixer;
   import ofwm_pkg::*;

   localparam int CLK_HALF = 2;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REG_BYTES = 4;
   localparam int N_PHASES = 8;
   localparam int PHASE0_RANDOM = 140;
   localparam int PHASE_ITEMS = 155;
   localparam int MAX_REPORTS = 10;

   // wheel sign pattern: x negated on wheels 1,2; y negated on wheels 2,3
   localparam logic [N_WHEELS-1:0] X_FLIP = 4'b0110;
   localparam logic [N_WHEELS-1:0] Y_FLIP = 4'b1100;

   typedef struct packed {
      logic [N_WHEELS-1:0][DUTY_W-1:0] fwd;
      logic [N_WHEELS-1:0][DUTY_W-1:0] rev;
   } wheel_duty_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] x;
      logic signed [CMD_W-1:0] y;
      logic signed [CMD_W-1:0] r;
      logic                    brk;
      logic                    fixed;
      logic [31:0]             fwd;
      logic [31:0]             rev;
   } dir_row_type;

   localparam int N_DIR = 22;

   dir_row_type dir_rows [N_DIR] = '{
      '{16'sd0,     16'sd0,     16'sd0,     1'b0, 1'b1, 32'h00000000, 32'h00000000},
      '{16'sd0,     16'sd0,     16'sd0,     1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF},
      '{16'sd32767, 16'sd32767, 16'sd0,     1'b0, 1'b1, 32'h000000FF, 32'h00FF0000},
      '{16'sh8000,  16'sh8000,  16'sd0,     1'b0, 1'b1, 32'h00FF0000, 32'h000000FF},
      '{16'sd32767, 16'sh8000,  16'sd0,     1'b0, 1'b1, 32'hFF000000, 32'h0000FF00},
      '{16'sd0,     16'sd0,     16'sd9,     1'b0, 1'b1, 32'h09090909, 32'h00000000},
      '{16'sd0,     16'sd0,     -16'sd9,    1'b0, 1'b1, 32'h00000000, 32'h09090909},
      '{16'sd0,     16'sd0,     16'sd10,    1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd0,     16'sd0,     -16'sd10,   1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd0,     16'sd0,     16'sd32767, 1'b0, 1'b1, 32'hFFFFFFFF, 32'h00000000},
      '{16'sd0,     16'sd0,     16'sh8000,  1'b0, 1'b1, 32'h00000000, 32'hFFFFFFFF},
      '{16'sd100,   16'sd0,     16'sd0,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd0,     16'sd100,   16'sd0,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd1,     16'sd0,     16'sd0,     1'b0, 1'b1, 32'h00000000, 32'h00000000},
      '{-16'sd1,    -16'sd1,    16'sd1,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd255,   16'sd0,     16'sd0,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd365,   16'sd0,     16'sd0,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd366,   16'sd0,     16'sd0,     1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF},
      '{-16'sd1,    16'sd0,     -16'sd1,    1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sd1000,  -16'sd300,  -16'sd9,    1'b0, 1'b0, 32'h0, 32'h0},
      '{16'sh8000,  16'sd32767, 16'sh8000,  1'b0, 1'b0, 32'h0, 32'h0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ofwm_req_if req_bus ();
   ofwm_rsp_if rsp_bus ();

   omni_four_wheel_mixer dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   bias_set_type   wheel_bias_q;
   wheel_duty_type pending_duties [$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic wheel_duty_type mix_wheels(input logic signed [CMD_W-1:0] x,
                                                 input logic signed [CMD_W-1:0] y,
                                                 input logic signed [CMD_W-1:0] r,
                                                 input logic brk, input bias_set_type bias);
      longint thr [N_WHEELS];
      longint rot_gain, mix, prod, mag, peak;
      bit over;
      wheel_duty_type d;
      peak = 0;
      over = 1'b0;
      rot_gain = (r > -ROT_LIMIT && r < ROT_LIMIT) ? GAIN_ROT_FULL : GAIN_ROT_LOW;
      for (int w = 0; w < N_WHEELS; w++) begin
         mix = ((X_FLIP[w] ? -longint'(x) : longint'(x)) +
                (Y_FLIP[w] ? -longint'(y) : longint'(y))) * GAIN_XY + longint'(r) * rot_gain;
         prod = mix * longint'($signed(bias[w]));
         thr[w] = prod < 0 ? -((-prod) >> PRODUCT_SHIFT) : prod >> PRODUCT_SHIFT;
         mag = thr[w] < 0 ? -thr[w] : thr[w];
         if (mag > DUTY_MAX) over = 1'b1;
         if (mag > peak) peak = mag;
      end
      for (int w = 0; w < N_WHEELS; w++) begin
         if (over) begin
            prod = thr[w] * DUTY_MAX;
            mag = (prod < 0 ? -prod : prod) / peak;
            thr[w] = prod < 0 ? -mag : mag;
         end
         mag = thr[w] < 0 ? -thr[w] : thr[w];
         d.fwd[w] = brk ? DUTY_W'(DUTY_MAX) : (thr[w] >= 0 ? DUTY_W'(mag) : '0);
         d.rev[w] = brk ? DUTY_W'(DUTY_MAX) : (thr[w] < 0 ? DUTY_W'(mag) : '0);
      end
      return d;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [CMD_W-1:0] pick_speed();
      case ($urandom_range(0, 9))
         0, 1, 2: return CMD_W'($urandom_range(0, 65535));
         3, 4:    return CMD_W'(int'($urandom_range(0, 800)) - 400);
         5:       return CMD_W'(int'($urandom_range(0, 24)) - 12);
         6:       return CMD_W'(int'($urandom_range(0, 8000)) - 4000);
         7: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: return CMD_W'(int'($urandom_range(0, 80)) - 40);
      endcase
   endfunction

   function automatic logic [BIAS_W-1:0] pick_bias();
      if ($urandom_range(0, 1) == 0) return BIAS_W'(int'($urandom_range(0, 16384)) - 8192);
      return BIAS_W'($urandom);
   endfunction

   task automatic send_cmd(input logic signed [CMD_W-1:0] x, input logic signed [CMD_W-1:0] y,
                           input logic signed [CMD_W-1:0] r, input logic brk,
                           input logic fixed, input logic [31:0] fwd, input logic [31:0] rev);
      int gap;
      wheel_duty_type want;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.move_x <= x;
      req_bus.move_y <= y;
      req_bus.turn_rate <= r;
      req_bus.brake <= brk;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      want = mix_wheels(x, y, r, brk, wheel_bias_q);
      if (fixed) begin
         want.fwd = fwd;
         want.rev = rev;
      end
      pending_duties.push_back(want);
   endtask

   task automatic send_random();
      send_cmd(pick_speed(), pick_speed(), pick_speed(), $urandom_range(0, 7) == 0,
               1'b0, '0, '0);
   endtask

   // back-to-back APB writes; caller closes the transfer
   task automatic write_bias(input int idx, input logic [BIAS_W-1:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx * REG_BYTES);
      csr_pwdata <= {16'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      wheel_bias_q[idx] = val;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input wheel_duty_type want,
                                input wheel_duty_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s: expected fwd=%h rev=%h, got fwd=%h rev=%h",
                  what, want.fwd, want.rev, got.fwd, got.rev);
   endtask

   always @(posedge clock) begin
      wheel_duty_type got, want;
      bit bad;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.fwd = {rsp_bus.w3_fwd_duty, rsp_bus.w2_fwd_duty,
                    rsp_bus.w1_fwd_duty, rsp_bus.w0_fwd_duty};
         got.rev = {rsp_bus.w3_rev_duty, rsp_bus.w2_rev_duty,
                    rsp_bus.w1_rev_duty, rsp_bus.w0_rev_duty};
         if (pending_duties.size() == 0) begin
            note_mismatch("unexpected word", '0, got);
         end else begin
            want = pending_duties.pop_front();
            bad = 1'b0;
            for (int w = 0; w < N_WHEELS; w++)
               if (got.fwd[w] !== want.fwd[w] || got.rev[w] !== want.rev[w]) bad = 1'b1;
            if (bad) note_mismatch("duty mismatch", want, got);
         end
      end
   end

   // result side: ready bursts with random stalls, held high in the no-idle phases
   initial begin
      int run, stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = no_idle ? 50 : $urandom_range(1, 12);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (!no_idle) begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.move_x <= '0;
      req_bus.move_y <= '0;
      req_bus.turn_rate <= '0;
      req_bus.brake <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      for (int w = 0; w < N_WHEELS; w++) wheel_bias_q[w] = BIAS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++)
         send_cmd(dir_rows[i].x, dir_rows[i].y, dir_rows[i].r, dir_rows[i].brk,
                  dir_rows[i].fixed, dir_rows[i].fwd, dir_rows[i].rev);
      repeat (PHASE0_RANDOM) send_random();

      for (int ph = 1; ph <= N_PHASES; ph++) begin
         drain();
         for (int w = 0; w < N_WHEELS; w++) begin
            case (ph)
               1:       write_bias(w, 16'h7FFF);
               2:       write_bias(w, 16'h8000);
               3:       write_bias(w, w == 0 ? 16'h0000 : w == 1 ? 16'h0001 :
                                      w == 2 ? 16'hFFFF : BIAS_RESET);
               4:       write_bias(w, w == 0 ? 16'h7FFF : w == 1 ? 16'h8000 :
                                      w == 2 ? 16'hF000 : 16'h0800);
               default: write_bias(w, pick_bias());
            endcase
         end
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         no_idle = (ph == 3 || ph == 7);
         repeat (PHASE_ITEMS) send_random();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
